@@ hdl/lhtrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lhtrs_pkg
// Shared constants, codes and types of the line hit-test range search block.
// ----------------------------------------------------------------------------
package lhtrs_pkg;

    localparam int MAX_CHARS  = 256;
    localparam int MAX_WORDS  = 64;
    localparam int COORD_BITS = 24;

    localparam int CHAR_AW = $clog2(MAX_CHARS);
    localparam int CHAR_CW = $clog2(MAX_CHARS + 1);
    localparam int WORD_AW = $clog2(MAX_WORDS);
    localparam int WORD_CW = $clog2(MAX_WORDS + 1);
    localparam int SRCH_W  = (CHAR_CW > WORD_CW) ? CHAR_CW : WORD_CW;
    localparam int SUM_W   = COORD_BITS + 1;

    localparam int MODE_W    = 3;
    localparam int FIRST_W   = 8;
    localparam int HIT_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam int IN_TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;

    localparam int FOUND_LSB    = 0;
    localparam int FIRST_LSB    = FOUND_LSB + 1;
    localparam int HIT_LSB      = FIRST_LSB + FIRST_W;
    localparam int STATUS_LSB   = HIT_LSB + HIT_W;
    localparam int OUT_FIELDS_W = STATUS_LSB + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_LOAD_CHAR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_WORD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REGION    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POINT     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_RIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_TOP    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_BOTTOM = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

    typedef struct packed {
        logic overlap;
        logic holds;
    } geom_flags_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_OVERLAP,
        S_S1_RD,
        S_S1_CMP,
        S_FIRST_RD,
        S_FIRST_CHK,
        S_S2_RD,
        S_S2_CMP,
        S_LAST_RD,
        S_LAST_CHK,
        S_WORD_RD,
        S_WORD_CMP,
        S_WCHK_RD,
        S_WCHK,
        S_DONE
    } state_t;

endpackage

@@ hdl/lhtrs_geom.sv @@
// ----------------------------------------------------------------------------
// lhtrs_geom
// Rectangle overlap and point containment against the line rectangle.
// ----------------------------------------------------------------------------
module lhtrs_geom import lhtrs_pkg::*; (
    input  coord_t      line_left,
    input  coord_t      line_right,
    input  coord_t      line_top,
    input  coord_t      line_bottom,
    input  coord_t      q_left,
    input  coord_t      q_right,
    input  coord_t      q_top,
    input  coord_t      q_bottom,
    output geom_flags_t flags
);

    coord_t l1, r1, t1, b1;
    coord_t l2, r2, t2, b2;
    logic   line_ok;
    logic   q_ok;

    always_comb begin
        l1 = (line_left < line_right) ? line_left : line_right;
        r1 = (line_left < line_right) ? line_right : line_left;
        t1 = (line_top < line_bottom) ? line_top : line_bottom;
        b1 = (line_top < line_bottom) ? line_bottom : line_top;
        l2 = (q_left < q_right) ? q_left : q_right;
        r2 = (q_left < q_right) ? q_right : q_left;
        t2 = (q_top < q_bottom) ? q_top : q_bottom;
        b2 = (q_top < q_bottom) ? q_bottom : q_top;

        line_ok = (l1 != r1) && (t1 != b1);
        q_ok    = (l2 != r2) && (t2 != b2);

        flags.overlap = line_ok && q_ok && (l1 < r2) && (l2 < r1) && (t1 < b2) && (t2 < b1);
        flags.holds   = line_ok && (q_left >= l1) && (q_left <= r1)
                        && (q_top >= t1) && (q_top <= b1);
    end

endmodule

@@ hdl/line_hit_test_range_search.sv @@
// ----------------------------------------------------------------------------
// line_hit_test_range_search
// Hit-tests one text line against sorted character and word tables.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+-----------------------------
//   s_       | in        | s_tvalid / s_tready | s_tuser mode, s_tdata coords
//   m_       | out       | m_tvalid / m_tready | m_tdata result
//   cfg_     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Loads, clear and unused modes go from decode straight to the result.
// Each binary-search step of a region query is one read and one compare on the
// character memory; a point query first searches the word memory the same way.
// Reset clears the counts and line registers; no memory pass is needed.
// A waiting result does not block the next request; it blocks completion.
// ----------------------------------------------------------------------------
module line_hit_test_range_search import lhtrs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // x_low, x_high, y_low, y_high
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // mode
    input  logic [MODE_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // found, first_index, hit_count, status, zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_BITS-1:0]  cfg_data
);

    state_t state_reg, state_next;

    coord_t line_left_reg, line_right_reg, line_top_reg, line_bottom_reg;
    logic [CHAR_CW-1:0] char_count_reg;
    logic [WORD_CW-1:0] word_count_reg;
    logic               m_tvalid_reg;

    logic [MODE_W-1:0]  mode_reg;
    coord_t             xl_reg, xh_reg, yl_reg, yh_reg;
    logic [SRCH_W-1:0]  lo_reg, n_reg, first_reg;
    logic               res_found_reg, res_status_reg;
    logic [FIRST_W-1:0] res_first_reg;
    logic [HIT_W-1:0]   res_hit_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    sum_t                    char_mem [MAX_CHARS];
    logic [2*COORD_BITS-1:0] word_mem [MAX_WORDS];
    sum_t                    char_rdata_reg;
    logic [2*COORD_BITS-1:0] word_rdata_reg;

    logic [CHAR_AW-1:0] char_raddr;
    logic [WORD_AW-1:0] word_raddr;
    logic [SRCH_W-1:0]  half, probe, last_idx, char_count_ext, word_count_ext;
    sum_t               twice_left, twice_right, load_sum;
    coord_t             word_start, word_end;
    logic               char_full, word_full, in_word, out_load;
    logic [OUT_TDATA_W-1:0] out_word;
    geom_flags_t        geom;

    lhtrs_geom u_geom (
        .line_left   (line_left_reg),
        .line_right  (line_right_reg),
        .line_top    (line_top_reg),
        .line_bottom (line_bottom_reg),
        .q_left      (xl_reg),
        .q_right     (xh_reg),
        .q_top       (yl_reg),
        .q_bottom    (yh_reg),
        .flags       (geom)
    );

    assign half           = n_reg >> 1;
    assign probe          = lo_reg + half;
    assign last_idx       = lo_reg - SRCH_W'(1);
    assign char_count_ext = SRCH_W'(char_count_reg);
    assign word_count_ext = SRCH_W'(word_count_reg);
    assign twice_left     = {xl_reg, 1'b0};
    assign twice_right    = {xh_reg, 1'b0};
    assign load_sum       = {xl_reg[COORD_BITS-1], xl_reg} + {xh_reg[COORD_BITS-1], xh_reg};
    assign word_start     = word_rdata_reg[COORD_BITS-1:0];
    assign word_end       = word_rdata_reg[2*COORD_BITS-1:COORD_BITS];
    assign char_full      = (char_count_reg == CHAR_CW'(MAX_CHARS));
    assign word_full      = (word_count_reg == WORD_CW'(MAX_WORDS));
    assign in_word        = (word_start <= xl_reg) && (xl_reg <= word_end);

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DECODE;
            end
            S_DECODE: begin
                unique case (mode_reg)
                    MODE_REGION: state_next = S_OVERLAP;
                    MODE_POINT:  state_next = geom.holds ? S_WORD_RD : S_DONE;
                    default:     state_next = S_DONE;
                endcase
            end
            S_OVERLAP:   state_next = geom.overlap ? S_S1_RD : S_DONE;
            S_S1_RD:     state_next = (n_reg == '0) ? S_FIRST_RD : S_S1_CMP;
            S_S1_CMP:    state_next = S_S1_RD;
            S_FIRST_RD:  state_next = (first_reg >= char_count_ext) ? S_DONE : S_FIRST_CHK;
            S_FIRST_CHK: state_next = (char_rdata_reg > twice_right) ? S_DONE : S_S2_RD;
            S_S2_RD:     state_next = (n_reg == '0) ? S_LAST_RD : S_S2_CMP;
            S_S2_CMP:    state_next = S_S2_RD;
            S_LAST_RD:   state_next = (lo_reg == '0) ? S_DONE : S_LAST_CHK;
            S_LAST_CHK:  state_next = S_DONE;
            S_WORD_RD:   state_next = (n_reg == '0) ? S_WCHK_RD : S_WORD_CMP;
            S_WORD_CMP:  state_next = S_WORD_RD;
            S_WCHK_RD:   state_next = (lo_reg >= word_count_ext) ? S_DONE : S_WCHK;
            S_WCHK:      state_next = in_word ? S_OVERLAP : S_DONE;
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == S_IDLE);
        out_load   = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
        char_raddr = '0;
        word_raddr = '0;
        unique case (state_reg)
            S_S1_RD, S_S2_RD: char_raddr = probe[CHAR_AW-1:0];
            S_FIRST_RD:       char_raddr = first_reg[CHAR_AW-1:0];
            S_LAST_RD:        char_raddr = last_idx[CHAR_AW-1:0];
            S_WORD_RD:        word_raddr = probe[WORD_AW-1:0];
            S_WCHK_RD:        word_raddr = lo_reg[WORD_AW-1:0];
            default: begin
                char_raddr = '0;
                word_raddr = '0;
            end
        endcase
        out_word = '0;
        out_word[FOUND_LSB]                 = res_found_reg;
        out_word[FIRST_LSB +: FIRST_W]      = res_first_reg;
        out_word[HIT_LSB +: HIT_W]          = res_hit_reg;
        out_word[STATUS_LSB]                = res_status_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            line_left_reg   <= '0;
            line_right_reg  <= '0;
            line_top_reg    <= '0;
            line_bottom_reg <= '0;
            char_count_reg  <= '0;
            word_count_reg  <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_LINE_LEFT:   line_left_reg   <= cfg_data;
                    CFG_LINE_RIGHT:  line_right_reg  <= cfg_data;
                    CFG_LINE_TOP:    line_top_reg    <= cfg_data;
                    CFG_LINE_BOTTOM: line_bottom_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == S_DECODE) begin
                case (mode_reg)
                    MODE_LOAD_CHAR: begin
                        if (!char_full) char_count_reg <= char_count_reg + CHAR_CW'(1);
                    end
                    MODE_LOAD_WORD: begin
                        if (!word_full) word_count_reg <= word_count_reg + WORD_CW'(1);
                    end
                    MODE_CLEAR: begin
                        char_count_reg <= '0;
                        word_count_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg <= s_tuser;
            xl_reg   <= s_tdata[0*COORD_BITS +: COORD_BITS];
            xh_reg   <= s_tdata[1*COORD_BITS +: COORD_BITS];
            yl_reg   <= s_tdata[2*COORD_BITS +: COORD_BITS];
            yh_reg   <= s_tdata[3*COORD_BITS +: COORD_BITS];
        end
        if (out_load) m_tdata_reg <= out_word;
        case (state_reg)
            S_DECODE: begin
                res_found_reg  <= 1'b0;
                res_first_reg  <= '0;
                res_hit_reg    <= '0;
                res_status_reg <= ((mode_reg == MODE_LOAD_CHAR) && char_full)
                                  || ((mode_reg == MODE_LOAD_WORD) && word_full);
                lo_reg <= '0;
                n_reg  <= word_count_ext;
            end
            S_OVERLAP, S_FIRST_CHK: begin
                lo_reg <= '0;
                n_reg  <= char_count_ext;
            end
            S_S1_RD: begin
                if (n_reg == '0) first_reg <= lo_reg;
            end
            S_S1_CMP: begin
                if (char_rdata_reg < twice_left) begin
                    lo_reg <= probe + SRCH_W'(1);
                    n_reg  <= n_reg - half - SRCH_W'(1);
                end else begin
                    n_reg  <= half;
                end
            end
            S_S2_CMP: begin
                if (char_rdata_reg <= twice_right) begin
                    lo_reg <= probe + SRCH_W'(1);
                    n_reg  <= n_reg - half - SRCH_W'(1);
                end else begin
                    n_reg  <= half;
                end
            end
            S_WORD_CMP: begin
                if (word_end < xl_reg) begin
                    lo_reg <= probe + SRCH_W'(1);
                    n_reg  <= n_reg - half - SRCH_W'(1);
                end else begin
                    n_reg  <= half;
                end
            end
            S_WCHK: begin
                xl_reg <= word_start;
                xh_reg <= word_end;
                yl_reg <= line_top_reg;
                yh_reg <= line_bottom_reg;
            end
            S_LAST_CHK: begin
                if (!(char_rdata_reg < twice_left) && !(last_idx < first_reg)) begin
                    res_found_reg <= 1'b1;
                    res_first_reg <= FIRST_W'(first_reg);
                    res_hit_reg   <= HIT_W'(lo_reg - first_reg);
                end
            end
            default: ;
        endcase
    end

    // write on accepted load, read every cycle
    always_ff @(posedge aclk) begin
        if ((state_reg == S_DECODE) && (mode_reg == MODE_LOAD_CHAR) && !char_full) begin
            char_mem[char_count_reg[CHAR_AW-1:0]] <= load_sum;
        end
        char_rdata_reg <= char_mem[char_raddr];
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DECODE) && (mode_reg == MODE_LOAD_WORD) && !word_full) begin
            word_mem[word_count_reg[WORD_AW-1:0]] <= {xh_reg, xl_reg};
        end
        word_rdata_reg <= word_mem[word_raddr];
    end

endmodule

@@ hdl/lhtrs_checker.sv @@
// ----------------------------------------------------------------------------
// lhtrs_checker
// Port-level checks on the results of the line hit-test block.
// ----------------------------------------------------------------------------
module lhtrs_checker import lhtrs_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_refused_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[STATUS_LSB] |-> !m_tdata[FOUND_LSB])
        else $error("refused load reports a hit");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[FOUND_LSB] |->
            (m_tdata[FIRST_LSB +: FIRST_W] == '0) && (m_tdata[HIT_LSB +: HIT_W] == '0))
        else $error("miss carries nonzero index or count");

    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[FOUND_LSB] |-> (m_tdata[HIT_LSB +: HIT_W] != '0))
        else $error("hit with zero count");

endmodule

bind line_hit_test_range_search lhtrs_checker u_lhtrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line hit-test range search block.
//
// Loads sorted character boxes and word spans, programs the line rectangle
// between phases, and fires region and point queries around the loaded text
// together with some noise. Every response is checked against a behavioral
// model of the binary searches kept inside the bench. The request and
// response sides idle and stall at random, at different rates per phase.
// ----------------------------------------------------------------------------
module tb;
    import lhtrs_pkg::*;

    localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        logic [MODE_W-1:0] mode;
        coord_t            x_low;
        coord_t            x_high;
        coord_t            y_low;
        coord_t            y_high;
        bit                wait_drain;
    } hit_request_t;

    typedef struct packed {
        logic               found;
        logic [FIRST_W-1:0] first_ix;
        logic [HIT_W-1:0]   hits;
        logic               status;
    } hit_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COORD_BITS-1:0]  cfg_data = '0;

    // line registers and tables as the block should hold them
    longint line_l, line_r, line_t, line_b;
    longint char_lo [MAX_CHARS];
    longint char_hi [MAX_CHARS];
    longint word_lo [MAX_WORDS];
    longint word_hi [MAX_WORDS];
    int     char_n, word_n;

    hit_request_t requests_todo[$];
    hit_request_t on_bus;
    hit_result_t  hits_due[$];

    int send_idle_pct, recv_stall_pct;
    int n_accepted, n_checked, n_errors, n_pushed, n_settings;
    int n_region, n_point, n_found, n_refused;
    int quiet;
    longint text_x, text_top, text_bot;

    line_hit_test_range_search DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic bit region_meets_line(longint rl, longint rr, longint rt, longint rb);
        longint l1, r1, t1, b1, l2, r2, t2, b2;
        l1 = (line_l < line_r) ? line_l : line_r;
        r1 = (line_l < line_r) ? line_r : line_l;
        t1 = (line_t < line_b) ? line_t : line_b;
        b1 = (line_t < line_b) ? line_b : line_t;
        l2 = (rl < rr) ? rl : rr;
        r2 = (rl < rr) ? rr : rl;
        t2 = (rt < rb) ? rt : rb;
        b2 = (rt < rb) ? rb : rt;
        if (l1 == r1 || t1 == b1 || l2 == r2 || t2 == b2) return 1'b0;
        if (l1 >= r2 || l2 >= r1) return 1'b0;
        if (t1 >= b2 || t2 >= b1) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit line_contains(longint x, longint y);
        longint l, r, t, b;
        l = (line_l < line_r) ? line_l : line_r;
        r = (line_l < line_r) ? line_r : line_l;
        t = (line_t < line_b) ? line_t : line_b;
        b = (line_t < line_b) ? line_b : line_t;
        if (l == r || t == b) return 1'b0;
        return x >= l && x <= r && y >= t && y <= b;
    endfunction

    function automatic longint twice_centre(int i);
        return char_lo[i] + char_hi[i];
    endfunction

    function automatic hit_result_t chars_in_region(longint rl, longint rr,
                                                    longint rt, longint rb);
        hit_result_t res;
        int lo, n, half, first_ix, past;
        res = '0;
        if (!region_meets_line(rl, rr, rt, rb)) return res;
        lo = 0;
        n = char_n;
        while (n > 0) begin
            half = n / 2;
            if (twice_centre(lo + half) < 2 * rl) begin
                lo = lo + half + 1;
                n = n - half - 1;
            end else begin
                n = half;
            end
        end
        first_ix = lo;
        if (first_ix >= char_n || twice_centre(first_ix) > 2 * rr) return res;
        lo = 0;
        n = char_n;
        while (n > 0) begin
            half = n / 2;
            if (!(2 * rr < twice_centre(lo + half))) begin
                lo = lo + half + 1;
                n = n - half - 1;
            end else begin
                n = half;
            end
        end
        past = lo;
        if (past == 0 || twice_centre(past - 1) < 2 * rl || past - 1 < first_ix) return res;
        res.found = 1'b1;
        res.first_ix = FIRST_W'(first_ix);
        res.hits = HIT_W'(past - first_ix);
        return res;
    endfunction

    function automatic hit_result_t hit_test(hit_request_t q);
        hit_result_t res;
        longint xl, xh, yl, yh;
        int lo, n, half;
        res = '0;
        xl = q.x_low;
        xh = q.x_high;
        yl = q.y_low;
        yh = q.y_high;
        case (q.mode)
            MODE_LOAD_CHAR: begin
                if (char_n >= MAX_CHARS) begin
                    res.status = 1'b1;
                    n_refused++;
                end else begin
                    char_lo[char_n] = xl;
                    char_hi[char_n] = xh;
                    char_n++;
                end
            end
            MODE_LOAD_WORD: begin
                if (word_n >= MAX_WORDS) begin
                    res.status = 1'b1;
                    n_refused++;
                end else begin
                    word_lo[word_n] = xl;
                    word_hi[word_n] = xh;
                    word_n++;
                end
            end
            MODE_CLEAR: begin
                char_n = 0;
                word_n = 0;
            end
            MODE_REGION: begin
                n_region++;
                res = chars_in_region(xl, xh, yl, yh);
            end
            MODE_POINT: begin
                n_point++;
                if (line_contains(xl, yl)) begin
                    lo = 0;
                    n = word_n;
                    while (n > 0) begin
                        half = n / 2;
                        if (word_hi[lo + half] < xl) begin
                            lo = lo + half + 1;
                            n = n - half - 1;
                        end else begin
                            n = half;
                        end
                    end
                    if (lo < word_n && word_lo[lo] <= xl && xl <= word_hi[lo])
                        res = chars_in_region(word_lo[lo], word_hi[lo], line_t, line_b);
                end
            end
            default: ;
        endcase
        if (res.found) n_found++;
        return res;
    endfunction

    always @(posedge aclk) begin : drive_requests
        bit took;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            took = s_tvalid && s_tready;
            if (took) begin
                hits_due.push_back(hit_test(on_bus));
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || took) begin
                if (requests_todo.size() != 0 && $urandom_range(99) >= send_idle_pct
                        && !(requests_todo[0].wait_drain
                             && (took || n_checked != n_accepted))) begin
                    on_bus = requests_todo.pop_front();
                    s_tuser <= on_bus.mode;
                    s_tdata <= {on_bus.y_high, on_bus.y_low, on_bus.x_high, on_bus.x_low};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic flag_field(input string field, input int want, input int got);
        n_errors++;
        if (n_errors <= 40)
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge aclk) begin : check_results
        hit_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.found = m_tdata[FOUND_LSB];
                got.first_ix = m_tdata[FIRST_LSB +: FIRST_W];
                got.hits = m_tdata[HIT_LSB +: HIT_W];
                got.status = m_tdata[STATUS_LSB];
                if (hits_due.size() == 0) begin
                    n_errors++;
                    $display("%0t ns: response with no request outstanding, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want = hits_due.pop_front();
                    if (got.found !== want.found) flag_field("found", want.found, got.found);
                    if (got.first_ix !== want.first_ix)
                        flag_field("first_index", want.first_ix, got.first_ix);
                    if (got.hits !== want.hits) flag_field("hit_count", want.hits, got.hits);
                    if (got.status !== want.status) flag_field("status", want.status, got.status);
                    n_checked <= n_checked + 1;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("line_hit_test_range_search regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic longint jitter(longint v, int span);
        return v - span + longint'($urandom_range(2 * span));
    endfunction

    function automatic longint rnd_coord();
        return longint'($urandom());
    endfunction

    function automatic longint edge_near(longint l, longint r);
        case ($urandom_range(2))
            0: return jitter(l, 20);
            1: return (l + r) >>> 1;
            default: return jitter((l + r) >>> 1, 20);
        endcase
    endfunction

    function automatic void send(input logic [MODE_W-1:0] mode, input longint xl,
                                 input longint xh, input longint yl, input longint yh,
                                 input bit hold = 1'b0);
        hit_request_t q;
        q.mode = mode;
        q.x_low = coord_t'(xl);
        q.x_high = coord_t'(xh);
        q.y_low = coord_t'(yl);
        q.y_high = coord_t'(yh);
        q.wait_drain = hold;
        requests_todo.push_back(q);
        n_pushed++;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input longint value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= COORD_BITS'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LINE_LEFT:   line_l = coord_t'(value);
            CFG_LINE_RIGHT:  line_r = coord_t'(value);
            CFG_LINE_TOP:    line_t = coord_t'(value);
            CFG_LINE_BOTTOM: line_b = coord_t'(value);
            default: ;
        endcase
    endtask

    task automatic write_line(input longint l, input longint r, input longint t,
                              input longint b);
        cfg_write(CFG_LINE_LEFT, l);
        cfg_write(CFG_LINE_RIGHT, r);
        cfg_write(CFG_LINE_TOP, t);
        cfg_write(CFG_LINE_BOTTOM, b);
        n_settings++;
        @(negedge aclk);
    endtask

    task automatic settle(input int extra);
        do @(negedge aclk);
        while (requests_todo.size() != 0 || s_tvalid || n_checked != n_accepted);
        repeat (extra) @(negedge aclk);
    endtask

    task automatic choose_line(input int phase);
        longint l, r, t, b, tmp;
        l = longint'($urandom_range(7000000)) - 4000000;
        r = l + 40000 + $urandom_range(360000);
        t = longint'($urandom_range(8000000)) - 4000000;
        b = t + 64 + $urandom_range(4000);
        case (phase)
            3: begin
                l = COORD_MIN; r = COORD_MAX; t = COORD_MIN; b = COORD_MAX;
            end
            5: r = l;
            6: begin
                tmp = l; l = r; r = tmp;
                tmp = t; t = b; b = tmp;
            end
            7: b = t;
            8: begin
                l = COORD_MAX; r = COORD_MIN; t = COORD_MAX; b = COORD_MIN;
            end
            default: ;
        endcase
        write_line(l, r, t, b);
        text_x = (l < r) ? l : r;
        text_top = (t < b) ? t : b;
        text_bot = (t < b) ? b : t;
        if (phase == 3 || phase == 8) text_x = jitter(0, 200000);
    endtask

    // clear, load a sorted line of text, then query around it
    task automatic build_frame(input bit big);
        longint cl[$], cr[$], ws[$], we[$];
        longint x, w, lft, rgt, y0, y1, span;
        int nc, i, j, k, nq, pick;
        send(MODE_CLEAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        if ($urandom_range(19) == 0)
            send(MODE_W'($urandom_range(7)), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        nc = big ? MAX_CHARS : (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24));
        x = jitter(text_x, 200);
        for (i = 0; i < nc; i++) begin
            w = big ? $urandom_range(40) : $urandom_range(400);
            cl.push_back(x);
            cr.push_back(x + w);
            send(MODE_LOAD_CHAR, x, x + w, rnd_coord(), rnd_coord());
            if ($urandom_range(15) == 0) x = x + w - $urandom_range(30);
            else x = x + w + $urandom_range(80);
        end
        for (i = 0; i < nc; i = j + 1) begin
            j = i + (big ? 3 : $urandom_range(4));
            if (j >= nc) j = nc - 1;
            ws.push_back(cl[i]);
            we.push_back(cr[j]);
            send(MODE_LOAD_WORD, cl[i], cr[j], rnd_coord(), rnd_coord());
        end
        if (big) begin
            repeat (2) begin
                send(MODE_LOAD_CHAR, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
                send(MODE_LOAD_WORD, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
            end
        end
        nq = big ? 40 : $urandom_range(6, 14);
        repeat (nq) begin
            pick = $urandom_range(99);
            y0 = jitter(text_top, 40);
            y1 = jitter(text_bot, 40);
            if (pick < 45 && nc > 0) begin
                i = $urandom_range(nc - 1);
                j = i + $urandom_range(4);
                if (j >= nc) j = nc - 1;
                lft = edge_near(cl[i], cr[i]);
                rgt = edge_near(cl[j], cr[j]);
                send(MODE_REGION, lft, rgt, y0, y1, $urandom_range(29) == 0);
            end else if (pick < 80 && ws.size() > 0) begin
                k = $urandom_range(ws.size() - 1);
                span = we[k] - ws[k];
                if (span < 0) span = 0;
                lft = ws[k] - 8 + $urandom_range(int'(span) + 16);
                if ($urandom_range(7) == 0) y0 = jitter(text_bot, 4);
                else y0 = text_top + $urandom_range(int'(text_bot - text_top));
                send(MODE_POINT, lft, rnd_coord(), y0, rnd_coord());
            end else if (pick < 92) begin
                lft = text_x - 1000 + $urandom_range(21000);
                rgt = lft - 200 + $urandom_range(20200);
                send(MODE_REGION, lft, rgt, y0, y1);
            end else begin
                send(MODE_W'($urandom_range(7)), rnd_coord(), rnd_coord(), rnd_coord(),
                     rnd_coord());
            end
        end
    endtask

    initial begin : run
        int budget;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: small sorted line of four boxes and three words
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_line(0, 64000, 0, 1280);
        send(MODE_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        send(MODE_REGION, 0, 2560, 0, 1280);
        send(MODE_POINT, 100, 0, 100, 0);
        send(MODE_LOAD_CHAR, 0, 640, COORD_MIN, COORD_MAX);
        send(MODE_LOAD_CHAR, 640, 1280, 0, 0);
        send(MODE_LOAD_CHAR, 1280, 1920, 0, 0);
        send(MODE_LOAD_CHAR, 1920, 2560, 0, 0);
        send(MODE_LOAD_WORD, 0, 1280, 0, 0);
        send(MODE_LOAD_WORD, 1280, 2560, 0, 0);
        send(MODE_LOAD_WORD, 3000, 3500, 0, 0);
        send(MODE_REGION, 0, 2560, 0, 1280, 1'b1);
        send(MODE_REGION, 320, 960, 0, 1280);
        send(MODE_REGION, 960, 320, 0, 1280);
        send(MODE_REGION, 0, 2560, 100, 100);
        send(MODE_REGION, -100, 0, 0, 1280);
        send(MODE_REGION, 0, 2560, 1280, 2000);
        send(MODE_POINT, 500, 0, 500, 0);
        send(MODE_POINT, 0, 0, 0, 0);
        send(MODE_POINT, 1280, 0, 640, 0);
        send(MODE_POINT, 500, 0, -1, 0);
        send(MODE_POINT, 2800, 0, 640, 0);
        send(MODE_POINT, 3200, 0, 640, 0);
        send(MODE_REGION, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        send(MODE_CLEAR, 0, 0, 0, 0);
        send(MODE_REGION, 0, 2560, 0, 1280);
        send(MODE_LOAD_CHAR, COORD_MAX, COORD_MIN, 0, 0);
        send(MODE_REGION, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
        settle(8);

        for (int phase = 1; phase <= 9; phase++) begin
            choose_line(phase);
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            budget = n_pushed + 50;
            if (phase == 2) build_frame(1'b1);
            while (n_pushed < budget) build_frame(1'b0);
            settle(8);
        end

        settle(64);
        $display("covered %0d requests over %0d line settings: %0d region, %0d point queries",
                 n_accepted, n_settings, n_region, n_point);
        $display("%0d queries hit characters, %0d loads refused on a full table",
                 n_found, n_refused);
        if (n_errors == 0 && hits_due.size() == 0) begin
            $display("line_hit_test_range_search regression: pass");
        end else begin
            $display("line_hit_test_range_search regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/lhtrs_pkg.sv
hdl/lhtrs_geom.sv
hdl/line_hit_test_range_search.sv
hdl/lhtrs_checker.sv
bench/tb.sv
